>>> hdl/tect_pkg.sv
// Shared types and character constants for the terminal escape code translator.
`default_nettype none
package tect_pkg;

  // Longest run one character can cause: ESC [ -rr ; -cc H.
  localparam int RunMax  = 10;
  localparam int RunLenW = $clog2(RunMax + 1);

  typedef logic [6:0] char_t;

  typedef struct packed {
    logic [RunMax-1:0][6:0] bytes;  // bytes[0] goes out first
    logic [RunLenW-1:0]     len;
  } run_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ESC      = 3'd1,
    PH_ATTR_ON  = 3'd2,
    PH_ATTR_OFF = 3'd3,
    PH_ROW      = 3'd4,
    PH_COL      = 3'd5
  } phase_t;

  // Terminal control codes.
  localparam char_t ChEsc         = 7'h1b;
  localparam char_t ChCurRight    = 7'h12;
  localparam char_t ChCurUp       = 7'h0b;
  localparam char_t ChClear       = 7'h1a;
  localparam char_t ChEraseLine   = 7'h18;
  localparam char_t ChEraseScreen = 7'h17;
  localparam char_t ChSelAttrOn   = 7'h42;  // 'B'
  localparam char_t ChSelAttrOff  = 7'h43;  // 'C'
  localparam char_t ChSelAddr     = 7'h3d;  // '='
  localparam char_t ChSwallowE    = 7'h45;  // 'E'
  localparam char_t ChSwallowR    = 7'h52;  // 'R'
  localparam char_t OffsetBias    = 7'd31;

  // ANSI characters.
  localparam char_t AsLBracket = 7'h5b;
  localparam char_t AsSemi     = 7'h3b;
  localparam char_t AsMinus    = 7'h2d;
  localparam char_t AsZero     = 7'h30;
  localparam char_t AsOne      = 7'h31;
  localparam char_t AsTwo      = 7'h32;
  localparam char_t AsThree    = 7'h33;
  localparam char_t AsFour     = 7'h34;
  localparam char_t AsFive     = 7'h35;
  localparam char_t AsSeven    = 7'h37;
  localparam char_t AsUpA      = 7'h41;
  localparam char_t AsUpC      = 7'h43;
  localparam char_t AsUpH      = 7'h48;
  localparam char_t AsUpJ      = 7'h4a;
  localparam char_t AsUpK      = 7'h4b;
  localparam char_t AsLowM     = 7'h6d;

endpackage
`default_nettype wire

>>> hdl/terminal_escape_code_translator.sv
// Top level of the terminal escape code translator: input handshake and output run buffer.
`default_nettype none
// Each input beat carries one character from the emulated CPU; bit 7 is
// ignored. The character is translated in the same cycle it is accepted and
// the resulting run of ANSI bytes (none to ten) is loaded into a shift buffer,
// from which one byte leaves per output beat, the final byte of a run with
// out_last set. Characters that only advance the escape state produce no
// output beats. A new character is taken when the buffer is empty or while
// its final byte is being taken, so one character per cycle is sustained for
// characters that cause at most one byte, as long as out_ready stays high;
// a character with a longer run holds off the next one until its final byte
// is taken. There is no configuration and no clearing pass after reset.
module terminal_escape_code_translator
  import tect_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_byte,
  output logic            out_last
);

  logic                   in_fire;
  logic                   out_fire;
  run_t                   run;
  logic [RunLenW-1:0]     cnt_r, cnt_nxt;
  logic [RunMax-1:0][6:0] bytes_r, bytes_nxt;

  // The buffer can take a new run once it is empty, or in the cycle its
  // final beat leaves.
  assign in_ready = (cnt_r == '0) || (cnt_r == RunLenW'(1) && out_ready);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  tect_xlate u_xlate (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .ch    (in_char[6:0]),
    .run   (run)
  );

  always_comb begin
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    if (in_fire) begin
      cnt_nxt   = run.len;
      bytes_nxt = run.bytes;
    end else if (out_fire) begin
      cnt_nxt   = cnt_r - RunLenW'(1);
      bytes_nxt = {7'd0, bytes_r[RunMax-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Payload needs no reset: it is only looked at while the count is non-zero.
  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  assign out_valid = (cnt_r != '0);
  assign out_byte  = bytes_r[0];
  assign out_last  = (cnt_r == RunLenW'(1));

endmodule
`default_nettype wire

>>> hdl/tect_xlate.sv
// Escape state and the translation of one character into its output run.
`default_nettype none
module tect_xlate
  import tect_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire char_t ch,
  output run_t       run
);

  typedef struct packed {
    logic [2:0][6:0] d;
    logic [1:0]      len;
  } dec_t;

  phase_t phase_r, phase_nxt;
  char_t  row_r, row_nxt;

  // Signed decimal of (c - 31); the tens digit uses a reciprocal multiply,
  // exact for the magnitudes that occur here.
  function automatic dec_t enc_offset(input char_t c);
    dec_t        r;
    logic        neg;
    char_t       mag;
    logic [14:0] prod;
    logic [3:0]  tens;
    char_t       ones;
    neg  = (c < OffsetBias);
    mag  = neg ? (OffsetBias - c) : (c - OffsetBias);
    prod = 15'(mag) * 15'd205;
    tens = prod[14:11];
    ones = mag - 7'(tens) * 7'd10;
    r    = '0;
    if (neg) begin
      r.d[0] = AsMinus;
      r.len  = 2'd1;
    end
    if (mag >= 7'd10) begin
      r.d[r.len] = AsZero + 7'(tens);
      r.len      = r.len + 2'd1;
    end
    r.d[r.len] = AsZero + ones;
    r.len      = r.len + 2'd1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      row_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
    end
  end

  // Next escape phase.
  always_comb begin
    phase_nxt = PH_IDLE;
    row_nxt   = row_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (ch == ChEsc) begin
          phase_nxt = PH_ESC;
        end
      end
      PH_ESC: begin
        priority if (ch == ChSelAttrOn) begin
          phase_nxt = PH_ATTR_ON;
        end else if (ch == ChSelAttrOff) begin
          phase_nxt = PH_ATTR_OFF;
        end else if (ch == ChSelAddr) begin
          phase_nxt = PH_ROW;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_ROW: begin
        row_nxt   = ch;
        phase_nxt = PH_COL;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Output run for the current character.
  always_comb begin
    dec_t rd, cd;
    logic [RunLenW-1:0] pos;
    rd  = enc_offset(row_r);
    cd  = enc_offset(ch);
    pos = '0;
    run = '0;
    run.bytes[0] = ChEsc;
    unique case (phase_r)
      PH_IDLE: begin
        run.bytes[1] = AsLBracket;
        unique case (ch)
          ChEsc: run.len = '0;
          ChCurRight: begin
            run.bytes[2] = AsUpC;
            run.len      = RunLenW'(3);
          end
          ChCurUp: begin
            run.bytes[2] = AsUpA;
            run.len      = RunLenW'(3);
          end
          ChClear: begin
            run.bytes[2] = AsTwo;
            run.bytes[3] = AsUpJ;
            run.len      = RunLenW'(4);
          end
          ChEraseLine: begin
            run.bytes[2] = AsUpK;
            run.len      = RunLenW'(3);
          end
          ChEraseScreen: begin
            run.bytes[2] = AsUpJ;
            run.len      = RunLenW'(3);
          end
          default: begin
            run.bytes[0] = ch;
            run.len      = RunLenW'(1);
          end
        endcase
      end
      PH_ESC: begin
        if (ch == ChSelAttrOn || ch == ChSelAttrOff || ch == ChSelAddr ||
            ch == ChSwallowE || ch == ChSwallowR) begin
          run.len = '0;
        end else begin
          run.bytes[1] = ch;
          run.len      = RunLenW'(2);
        end
      end
      PH_ATTR_ON: begin
        run.bytes[1] = AsLBracket;
        run.bytes[3] = AsLowM;
        run.len      = RunLenW'(4);
        unique case (ch)
          AsZero:  run.bytes[2] = AsSeven;
          AsOne:   run.bytes[2] = AsTwo;
          AsTwo:   run.bytes[2] = AsFive;
          AsThree: run.bytes[2] = AsFour;
          default: run.len = '0;
        endcase
      end
      PH_ATTR_OFF: begin
        run.bytes[1] = AsLBracket;
        run.bytes[2] = AsTwo;
        run.bytes[4] = AsLowM;
        run.len      = RunLenW'(5);
        unique case (ch)
          AsZero:  run.bytes[3] = AsSeven;
          AsOne:   run.bytes[3] = AsTwo;
          AsTwo:   run.bytes[3] = AsFive;
          AsThree: run.bytes[3] = AsFour;
          default: run.len = '0;
        endcase
      end
      PH_ROW: run.len = '0;
      PH_COL: begin
        run.bytes[1] = AsLBracket;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < rd.len) begin
            run.bytes[RunLenW'(2 + k)] = rd.d[k];
          end
        end
        pos = RunLenW'(2) + RunLenW'(rd.len);
        run.bytes[pos] = AsSemi;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < cd.len) begin
            run.bytes[pos + RunLenW'(1 + k)] = cd.d[k];
          end
        end
        pos = pos + RunLenW'(1) + RunLenW'(cd.len);
        run.bytes[pos] = AsUpH;
        run.len        = pos + RunLenW'(1);
      end
      default: begin
        run.bytes[1] = ch;
        run.len      = RunLenW'(2);
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/tect_checker.sv
// Port-level checks for the terminal escape code translator and their binding.
`default_nettype none
module tect_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_char,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] out_byte,
  input wire logic       out_last
);

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output beat changed while stalled");

  // A waiting input beat holds its character until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_char))
    else $error("input beat changed while waiting");

  // No new character is taken in the middle of a run.
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a run is still draining");

  // With nothing buffered the input is always open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with an empty buffer");

  // Output beats only ever follow an accepted input beat.
  a_no_out_without_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("output beat appeared without an input beat");

endmodule

bind terminal_escape_code_translator tect_checker u_tect_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_char   (in_char),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
`default_nettype wire
